// File: hdl/mecanum_wheel_speed_mixer_assert.svh
// Assertion macros used by the mixer queue.
`ifndef MECANUM_WHEEL_SPEED_MIXER_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_MIXER_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define MWSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mixer assertion failed");
// Next-cycle implication, disabled during reset.
`define MWSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mixer assertion failed");
`endif

// File: hdl/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// mwsm_pkg
// Types, constants and helpers for the mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mwsm_pkg;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam logic signed [31:0] OneQ30  = 32'sd1073741824;

  localparam logic [2:0] CfgMode   = 3'd0;
  localparam logic [2:0] CfgOffCos = 3'd1;
  localparam logic [2:0] CfgOffSin = 3'd2;
  localparam logic [2:0] CfgOffX   = 3'd3;
  localparam logic [2:0] CfgOffY   = 3'd4;
  localparam logic [2:0] CfgLsum   = 3'd5;
  localparam logic [2:0] CfgInvR   = 3'd6;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusMiss = 2'd1;
  localparam logic [1:0] StatusSat  = 2'd2;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] wz;
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic               miss;
  } item_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn.
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > 66'sd2147483647) || (v < -66'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// File: hdl/mwsm_front.sv
// ----------------------------------------------------------------------------
// mwsm_front
// Accepts commands, classifies the frame mode and runs the yaw CORDIC pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mwsm_front #(
  parameter int unsigned Steps = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [31:0]         vx_i,
  input  wire  [31:0]         vy_i,
  input  wire  [31:0]         wz_i,
  input  wire  [15:0]         yaw_i,
  input  wire                 yaw_valid_i,
  input  wire                 world_mode_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output mwsm_pkg::item_t     out_item_o
);
  import mwsm_pkg::*;

  logic [Steps:0]     v_q;
  logic signed [33:0] x_q [Steps+1];
  logic signed [33:0] y_q [Steps+1];
  logic signed [33:0] z_q [Steps+1];
  logic [31:0]        vx_q [Steps+1];
  logic [31:0]        vy_q [Steps+1];
  logic [31:0]        wz_q [Steps+1];
  logic [Steps:0]     flip_q, world_q, miss_q;
  logic               en;
  logic [31:0]        angle, angle_a;
  logic               flip;

  assign en         = !v_q[Steps] || out_ready_i;
  assign in_ready_o = en;

  // Second and third quadrants are folded by half a turn, results negated.
  assign angle   = {yaw_i, 16'h0000};
  assign flip    = angle[31] ^ angle[30];
  assign angle_a = {angle[31] ^ flip, angle[30:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Steps-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]     <= GainQ30;
      y_q[0]     <= '0;
      z_q[0]     <= {{2{angle_a[31]}}, angle_a};
      vx_q[0]    <= vx_i;
      vy_q[0]    <= vy_i;
      wz_q[0]    <= wz_i;
      flip_q[0]  <= flip;
      world_q[0] <= world_mode_i;
      miss_q[0]  <= world_mode_i && !yaw_valid_i;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [33:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = atan_turn(5'(i));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        vx_q[i+1]    <= vx_q[i];
        vy_q[i+1]    <= vy_q[i];
        wz_q[i+1]    <= wz_q[i];
        flip_q[i+1]  <= flip_q[i];
        world_q[i+1] <= world_q[i];
        miss_q[i+1]  <= miss_q[i];
      end
    end
  end

  logic signed [33:0] xf, yf;
  assign xf = flip_q[Steps] ? -x_q[Steps] : x_q[Steps];
  assign yf = flip_q[Steps] ? -y_q[Steps] : y_q[Steps];

  // Body frame passes the command through with a unit rotation.
  always_comb begin
    out_item_o.vx   = vx_q[Steps];
    out_item_o.vy   = vy_q[Steps];
    out_item_o.wz   = wz_q[Steps];
    out_item_o.miss = miss_q[Steps];
    if (world_q[Steps]) begin
      out_item_o.c = xf[31:0];
      out_item_o.s = yf[31:0];
    end else begin
      out_item_o.c = OneQ30;
      out_item_o.s = '0;
    end
  end

  assign out_valid_o = v_q[Steps];
endmodule
`default_nettype wire

// File: hdl/mwsm_queue.sv
// ----------------------------------------------------------------------------
// mwsm_queue
// Short FIFO between the CORDIC front end and the mixing back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_speed_mixer_assert.svh"
module mwsm_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  output logic                push_ready_o,
  input  mwsm_pkg::item_t     push_item_i,
  output logic                pop_valid_o,
  input  wire                 pop_ready_i,
  output mwsm_pkg::item_t     pop_item_o
);
  import mwsm_pkg::*;

  localparam int unsigned Depth = 4;

  item_t      mem_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 3'(Depth);
  assign pop_valid_o  = cnt_q != 3'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 2'd1;
      if (pop)  rd_q <= rd_q + 2'd1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 3'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

  `MWSM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= 3'(Depth))
  `MWSM_ASSERT_NXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 3'd1)
  `MWSM_ASSERT_IMP(a_ptr_gap, 1'b1, (wr_q - rd_q) == cnt_q[1:0])
endmodule
`default_nettype wire

// File: hdl/mwsm_back.sv
// ----------------------------------------------------------------------------
// mwsm_back
// Eight-stage mixing pipeline: rotations, lever terms, wheel sums, scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mwsm_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  mwsm_pkg::item_t     in_item_i,
  input  wire  [15:0]         off_cos_i,
  input  wire  [15:0]         off_sin_i,
  input  wire  [31:0]         off_x_i,
  input  wire  [31:0]         off_y_i,
  input  wire  [30:0]         lsum_i,
  input  wire  [30:0]         inv_r_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [127:0]        out_speeds_o,
  output logic [1:0]          out_status_o
);
  import mwsm_pkg::*;

  logic [7:0] v_q;
  logic       en;
  assign en          = !v_q[7] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:0], in_valid_i};
    end
  end

  logic signed [15:0] oc, os;
  logic signed [31:0] ox, oy, ls, ir;
  assign oc = off_cos_i;
  assign os = off_sin_i;
  assign ox = off_x_i;
  assign oy = off_y_i;
  assign ls = {1'b0, lsum_i};
  assign ir = {1'b0, inv_r_i};

  // miss and saturation flags travel with the data
  logic [7:0] miss_q, sat_q;

  // stage 1: yaw rotation products
  logic signed [63:0] p_cvx_q, p_svy_q, p_cvy_q, p_svx_q;
  logic signed [31:0] wz1_q, wz2_q;
  // stage 2: rotated command
  logic signed [31:0] rx_q, ry_q;
  // stage 3: offset rotation and lever products
  logic signed [47:0] p_ocrx_q, p_osry_q, p_osrx_q, p_ocry_q;
  logic signed [63:0] p_oyw_q, p_oxw_q, p_lw_q;
  // stage 4
  logic signed [31:0] bx_q, by_q, lw4_q, lw5_q;
  logic signed [47:0] ly_q, lx_q;
  // stage 5
  logic signed [31:0] cx_q, cy_q;
  // stage 6, 7
  logic signed [31:0] t_q [4];
  logic signed [63:0] p_t_q [4];
  // stage 8
  logic signed [31:0] spd_q [4];

  logic signed [65:0] s_rx, s_ry, s_bx, s_by, s_lw, s_cx, s_cy;
  logic signed [47:0] r_ly, r_lx;
  logic signed [65:0] s_sum [4];
  logic signed [65:0] s_spd [4];
  logic               sat2, sat4, sat5, sat6, sat8;

  always_comb begin
    s_rx = (66'(p_cvx_q) + 66'(p_svy_q) + (66'sd1 <<< 29)) >>> 30;
    s_ry = (66'(p_cvy_q) - 66'(p_svx_q) + (66'sd1 <<< 29)) >>> 30;
    sat2 = ovf32(s_rx) || ovf32(s_ry);
    s_bx = (66'(p_ocrx_q) - 66'(p_osry_q) + 66'sd8192) >>> 14;
    s_by = (66'(p_osrx_q) + 66'(p_ocry_q) + 66'sd8192) >>> 14;
    s_lw = (66'(p_lw_q) + 66'sd32768) >>> 16;
    r_ly = 48'((66'(p_oyw_q) + 66'sd32768) >>> 16);
    r_lx = 48'((66'(p_oxw_q) + 66'sd32768) >>> 16);
    sat4 = ovf32(s_bx) || ovf32(s_by) || ovf32(s_lw);
    s_cx = 66'(bx_q) + 66'(ly_q);
    s_cy = 66'(by_q) - 66'(lx_q);
    sat5 = ovf32(s_cx) || ovf32(s_cy);
    s_sum[0] = 66'(cx_q) - 66'(cy_q) - 66'(lw5_q);
    s_sum[1] = 66'(cx_q) + 66'(cy_q) - 66'(lw5_q);
    s_sum[2] = 66'(cx_q) - 66'(cy_q) + 66'(lw5_q);
    s_sum[3] = 66'(cx_q) + 66'(cy_q) + 66'(lw5_q);
    sat6 = 1'b0;
    sat8 = 1'b0;
    for (int k = 0; k < 4; k++) begin
      sat6     = sat6 || ovf32(s_sum[k]);
      s_spd[k] = (66'(p_t_q[k]) + 66'sd32768) >>> 16;
      sat8     = sat8 || ovf32(s_spd[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cvx_q  <= 64'(in_item_i.c) * 64'(in_item_i.vx);
      p_svy_q  <= 64'(in_item_i.s) * 64'(in_item_i.vy);
      p_cvy_q  <= 64'(in_item_i.c) * 64'(in_item_i.vy);
      p_svx_q  <= 64'(in_item_i.s) * 64'(in_item_i.vx);
      wz1_q    <= in_item_i.wz;
      miss_q[0] <= in_item_i.miss;
      sat_q[0]  <= 1'b0;

      rx_q     <= sat32(s_rx);
      ry_q     <= sat32(s_ry);
      wz2_q    <= wz1_q;
      miss_q[1] <= miss_q[0];
      sat_q[1]  <= sat_q[0] || sat2;

      p_ocrx_q <= 48'(oc) * 48'(rx_q);
      p_osry_q <= 48'(os) * 48'(ry_q);
      p_osrx_q <= 48'(os) * 48'(rx_q);
      p_ocry_q <= 48'(oc) * 48'(ry_q);
      p_oyw_q  <= 64'(oy) * 64'(wz2_q);
      p_oxw_q  <= 64'(ox) * 64'(wz2_q);
      p_lw_q   <= 64'(ls) * 64'(wz2_q);
      miss_q[2] <= miss_q[1];
      sat_q[2]  <= sat_q[1];

      bx_q     <= sat32(s_bx);
      by_q     <= sat32(s_by);
      lw4_q    <= sat32(s_lw);
      ly_q     <= r_ly;
      lx_q     <= r_lx;
      miss_q[3] <= miss_q[2];
      sat_q[3]  <= sat_q[2] || sat4;

      cx_q     <= sat32(s_cx);
      cy_q     <= sat32(s_cy);
      lw5_q    <= lw4_q;
      miss_q[4] <= miss_q[3];
      sat_q[4]  <= sat_q[3] || sat5;

      for (int k = 0; k < 4; k++) begin
        t_q[k]   <= sat32(s_sum[k]);
        p_t_q[k] <= 64'(t_q[k]) * 64'(ir);
        spd_q[k] <= sat32(s_spd[k]);
      end
      miss_q[5] <= miss_q[4];
      sat_q[5]  <= sat_q[4] || sat6;
      miss_q[6] <= miss_q[5];
      sat_q[6]  <= sat_q[5];
      miss_q[7] <= miss_q[6];
      sat_q[7]  <= sat_q[6] || sat8;
    end
  end

  // A missing yaw in world mode stops the wheels.
  always_comb begin
    if (miss_q[7]) begin
      out_speeds_o = '0;
      out_status_o = StatusMiss;
    end else begin
      out_speeds_o = {spd_q[3], spd_q[2], spd_q[1], spd_q[0]};
      out_status_o = sat_q[7] ? StatusSat : StatusOk;
    end
  end
endmodule
`default_nettype wire

// File: hdl/mecanum_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Velocity command to four mecanum wheel speeds, fully pipelined.
// ----------------------------------------------------------------------------
// One command is taken per clock and one result leaves per clock. Commands pass
// through the yaw CORDIC front end, the four-entry queue and the multiply
// back end; the rate is set by the output handshake alone. Configuration
// registers are written through the cfg port; the user must write them only
// while the block is idle, which the block itself does not enforce, and they
// then take effect for the next command.
`timescale 1ns / 1ps
`default_nettype none
module mecanum_wheel_speed_mixer #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd_vx[31:0], cmd_vy[63:32], cmd_wz[95:64], yaw_angle[111:96]
  input  wire  [111:0] s_axis_tdata,
  // yaw_valid[0]
  input  wire  [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // fl_speed[31:0], bl_speed[63:32], br_speed[95:64], fr_speed[127:96]
  output logic [127:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [31:0]  cfg_data_i
);
  import mwsm_pkg::*;

  logic        mode_q;
  logic [15:0] off_cos_q, off_sin_q;
  logic [31:0] off_x_q, off_y_q;
  logic [30:0] lsum_q, inv_r_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      off_cos_q <= 16'd16384;
      off_sin_q <= '0;
      off_x_q   <= '0;
      off_y_q   <= '0;
      lsum_q    <= 31'd65536;
      inv_r_q   <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMode:   mode_q    <= cfg_data_i[0];
        CfgOffCos: off_cos_q <= cfg_data_i[15:0];
        CfgOffSin: off_sin_q <= cfg_data_i[15:0];
        CfgOffX:   off_x_q   <= cfg_data_i;
        CfgOffY:   off_y_q   <= cfg_data_i;
        CfgLsum:   lsum_q    <= cfg_data_i[30:0];
        CfgInvR:   inv_r_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  mwsm_front #(.Steps(CORDIC_STEPS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .vx_i         (s_axis_tdata[31:0]),
    .vy_i         (s_axis_tdata[63:32]),
    .wz_i         (s_axis_tdata[95:64]),
    .yaw_i        (s_axis_tdata[111:96]),
    .yaw_valid_i  (s_axis_tuser[0]),
    .world_mode_i (mode_q),
    .out_valid_o  (f_valid),
    .out_ready_i  (f_ready),
    .out_item_o   (f_item)
  );

  mwsm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  mwsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (b_valid),
    .in_ready_o   (b_ready),
    .in_item_i    (b_item),
    .off_cos_i    (off_cos_q),
    .off_sin_i    (off_sin_q),
    .off_x_i      (off_x_q),
    .off_y_i      (off_y_q),
    .lsum_i       (lsum_q),
    .inv_r_i      (inv_r_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_speeds_o (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );
endmodule
`default_nettype wire

// File: bench/mecanum_wheel_speed_mixer_test.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_test
// Self-checking bench: directed commands, then random commands under several
// register settings; each wheel-speed transaction is checked against a fixed
// expected row or a fixed-point model, with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mecanum_wheel_speed_mixer_test;
  import mwsm_pkg::*;

  localparam int CordicSteps = 16;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 60;
  localparam logic [2:0] CfgUnused = 3'd7;
  localparam logic signed [31:0] SMax = 32'sh7fffffff;
  localparam logic signed [31:0] SMin = 32'sh80000000;

  localparam longint AtanTurn [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  typedef logic signed [79:0] wide_t;

  typedef struct {
    logic signed [31:0] w [4];
    logic [1:0]         st;
  } speeds_t;

  typedef struct {
    logic               mode;
    logic signed [31:0] vx, vy, wz;
    logic [15:0]        yaw;
    logic               yv;
    logic               typed;
    logic signed [31:0] fl, bl, br, fr;
    logic [1:0]         st;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [111:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  wire          s_axis_tready, m_axis_tvalid, cfg_ready_o;
  wire  [127:0] m_axis_tdata;
  wire  [1:0]   m_axis_tuser;

  // register shadow
  logic               r_mode;
  logic signed [15:0] r_ocos, r_osin;
  logic signed [31:0] r_ox, r_oy;
  logic [30:0]        r_lsum, r_invr;

  speeds_t wheel_q [$];
  int  errors = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  row_t rows [$];

  mecanum_wheel_speed_mixer #(.CORDIC_STEPS(CordicSteps)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic wide_t round_shr(input wide_t v, input int n);
    return (v + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic wide_t clamp32(input wide_t v, inout logic hit);
    if (v > wide_t'(SMax)) begin
      hit = 1'b1;
      return wide_t'(SMax);
    end
    if (v < wide_t'(SMin)) begin
      hit = 1'b1;
      return wide_t'(SMin);
    end
    return v;
  endfunction

  function automatic speeds_t mix_speeds(input logic signed [31:0] vx_i,
                                         input logic signed [31:0] vy_i,
                                         input logic signed [31:0] wz_i,
                                         input logic [15:0] yaw_i, input logic yv_i);
    speeds_t r;
    logic hit;
    logic [31:0] ang, a;
    logic flip;
    wide_t vx, vy, wz, x, y, z, dx, dy, c, s, rx, ry, bx, by, cx, cy, lw, t;
    wide_t sums [4];
    hit = 1'b0;
    vx = vx_i;
    vy = vy_i;
    wz = wz_i;
    rx = vx;
    ry = vy;
    if (r_mode) begin
      if (!yv_i) begin
        foreach (r.w[k]) r.w[k] = '0;
        r.st = StatusMiss;
        return r;
      end
      ang  = {yaw_i, 16'h0};
      // second and third quadrant: rotate by half a turn, negate after
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      a    = flip ? ang + 32'h80000000 : ang;
      z    = $signed(a);
      x    = GainQ30;
      y    = '0;
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - AtanTurn[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + AtanTurn[i];
        end
      end
      c  = flip ? -x : x;
      s  = flip ? -y : y;
      rx = clamp32(round_shr(c * vx + s * vy, 30), hit);
      ry = clamp32(round_shr(c * vy - s * vx, 30), hit);
    end
    bx = clamp32(round_shr(wide_t'(r_ocos) * rx - wide_t'(r_osin) * ry, 14), hit);
    by = clamp32(round_shr(wide_t'(r_osin) * rx + wide_t'(r_ocos) * ry, 14), hit);
    cx = clamp32(bx + round_shr(wide_t'(r_oy) * wz, 16), hit);
    cy = clamp32(by - round_shr(wide_t'(r_ox) * wz, 16), hit);
    lw = clamp32(round_shr($signed({49'd0, r_lsum}) * wz, 16), hit);
    sums[0] = cx - cy - lw;
    sums[1] = cx + cy - lw;
    sums[2] = cx - cy + lw;
    sums[3] = cx + cy + lw;
    for (int k = 0; k < 4; k++) begin
      t = clamp32(sums[k], hit);
      r.w[k] = clamp32(round_shr(t * $signed({49'd0, r_invr}), 16), hit);
    end
    r.st = hit ? StatusSat : StatusOk;
    return r;
  endfunction

  function automatic void add_row(input row_t r);
    rows = {rows, r};
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CfgMode:   r_mode   = val[0];
      CfgOffCos: r_ocos   = val[15:0];
      CfgOffSin: r_osin   = val[15:0];
      CfgOffX:   r_ox     = val;
      CfgOffY:   r_oy     = val;
      CfgLsum:   r_lsum   = val[30:0];
      CfgInvR:   r_invr   = val[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_cmd(input logic signed [31:0] vx, input logic signed [31:0] vy,
                          input logic signed [31:0] wz, input logic [15:0] yaw,
                          input logic yv, input bit typed, input speeds_t fixed);
    int gap;
    speeds_t exp_w;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {yaw, wz, vy, vx};
    s_tuser  <= yv;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_w = typed ? fixed : mix_speeds(vx, vy, wz, yaw, yv);
    wheel_q = {wheel_q, exp_w};
  endtask

  function automatic logic signed [31:0] rand_vel();
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(6, 20);
    return v;
  endfunction

  function automatic logic signed [15:0] rand_q14();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // output side: random stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // result check
  always @(posedge clk_i) begin
    speeds_t e;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (wheel_q.size() == 0) begin
        $display("%0t: unexpected transaction data=%h status=%0d", $time,
                 m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = wheel_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (m_axis_tdata[32*k+:32] !== e.w[k]) begin
            $display("%0t: wheel %0d expected %0d actual %0d", $time, k, e.w[k],
                     $signed(m_axis_tdata[32*k+:32]));
            errors++;
          end
        end
        if (m_axis_tuser !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL mecanum_wheel_speed_mixer");
      $finish;
    end
  end

  initial begin
    speeds_t fx;
    row_t rw;
    logic [15:0] yaw;
    r_mode = 1'b0; r_ocos = 16'sd16384; r_osin = '0; r_ox = '0; r_oy = '0;
    r_lsum = 31'd65536; r_invr = 31'd65536;
    // mode, vx, vy, wz, yaw, yaw valid, typed, fl, bl, br, fr, status
    add_row('{0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, StatusOk});
    add_row('{0, SMax, 0, 0, 0, 1, 1, SMax, SMax, SMax, SMax, StatusOk});
    add_row('{0, SMin, 0, 0, 0, 1, 1, SMin, SMin, SMin, SMin, StatusOk});
    add_row('{0, 0, 0, SMax, 0, 1, 1, -SMax, -SMax, SMax, SMax, StatusOk});
    add_row('{0, 0, 0, SMin, 0, 1, 1, SMax, SMax, SMin, SMin, StatusSat});
    add_row('{0, SMax, SMin, 0, 0, 1, 1, SMax, -1, SMax, -1, StatusSat});
    add_row('{0, 0, SMax, 0, 16'h7fff, 0, 0, 0, 0, 0, 0, StatusOk});
    add_row('{0, 123456, -654321, 98765, 16'h1234, 1, 0, 0, 0, 0, 0, StatusOk});
    add_row('{1, SMax, 0, 0, 0, 0, 1, 0, 0, 0, 0, StatusMiss});
    add_row('{1, 65536, 0, 0, 16'h0000, 1, 0, 0, 0, 0, 0, StatusOk});
    add_row('{1, 65536, 32768, 0, 16'h4000, 1, 0, 0, 0, 0, 0, StatusOk});
    add_row('{1, 65536, -32768, 0, 16'h8000, 1, 0, 0, 0, 0, 0, StatusOk});
    add_row('{1, 65536, 65536, 0, 16'h7fff, 1, 0, 0, 0, 0, 0, StatusOk});
    add_row('{1, -65536, 65536, 1000, 16'hc000, 1, 0, 0, 0, 0, 0, StatusOk});
    add_row('{1, SMax, SMax, SMin, 16'h2000, 1, 0, 0, 0, 0, 0, StatusOk});
    add_row('{1, SMin, SMin, SMax, 16'hffff, 1, 0, 0, 0, 0, 0, StatusOk});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.mode != r_mode) begin
        wait_drained();
        write_reg(CfgMode, {31'd0, rw.mode});
      end
      fx.w[0] = rw.fl; fx.w[1] = rw.bl; fx.w[2] = rw.br; fx.w[3] = rw.fr;
      fx.st = rw.st;
      send_cmd(rw.vx, rw.vy, rw.wz, rw.yaw, rw.yv, rw.typed, fx);
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_reg(CfgMode, {31'd0, ph[0]});
      case (ph)
        1: begin
          write_reg(CfgOffCos, -32'sd16384); write_reg(CfgOffSin, 32'sd0);
          write_reg(CfgOffX, 32'sd13107); write_reg(CfgOffY, -32'sd6554);
        end
        2: begin
          write_reg(CfgOffCos, 32'sd0); write_reg(CfgOffSin, 32'sd16384);
          write_reg(CfgLsum, 32'd1); write_reg(CfgInvR, 32'd1);
        end
        3: begin
          write_reg(CfgOffCos, 32'sd0); write_reg(CfgOffSin, -32'sd16384);
          write_reg(CfgOffX, SMin); write_reg(CfgOffY, SMax);
        end
        4: begin
          write_reg(CfgOffX, 32'sd0); write_reg(CfgOffY, 32'sd0);
          write_reg(CfgLsum, 32'h7fffffff); write_reg(CfgInvR, 32'h7fffffff);
        end
        5: begin
          write_reg(CfgUnused, 32'hffffffff);
          write_reg(CfgLsum, 32'd0); write_reg(CfgInvR, 32'd0);
        end
        default: begin
          write_reg(CfgOffCos, {{16{1'b0}}, rand_q14()});
          write_reg(CfgOffSin, {{16{1'b0}}, rand_q14()});
          write_reg(CfgOffX, $urandom >>> 14);
          write_reg(CfgOffY, $urandom >>> 14);
          write_reg(CfgLsum, $urandom_range(1, 200000));
          write_reg(CfgInvR, $urandom_range(1, 1000000));
        end
      endcase
      for (int n = 0; n < 235; n++) begin
        if (n % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
        if (ph == 3 && n == 100) wait_drained();
        yaw = 16'($urandom);
        send_cmd(rand_vel(), rand_vel(), rand_vel(), yaw,
                 $urandom_range(0, 9) != 0, 1'b0, fx);
      end
    end
    no_idle = 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("PASS mecanum_wheel_speed_mixer");
    end else begin
      $display("FAIL mecanum_wheel_speed_mixer");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/mwsm_pkg.sv
hdl/mwsm_front.sv
hdl/mwsm_queue.sv
hdl/mwsm_back.sv
hdl/mecanum_wheel_speed_mixer.sv
bench/mecanum_wheel_speed_mixer_test.sv
